// ===== rtl/lpht_pkg.sv =====
// Shared types and constants for the linear-probing key table.
// No dependencies; used by rtl/linear_probe_hash_table.sv.
`default_nettype none

package lpht_pkg;

    // Table geometry: slot count must be a power of two (home slot is a mask)
    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int KEY_W      = 34;
    localparam int SLOT_W     = 6;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_ZERO_KEY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } fsm_t;

    typedef struct packed {
        op_t               operation;
        logic [KEY_W-1:0]  key;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } out_item_t;

endpackage : lpht_pkg

`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// Linear-probing key table: key memory, per-slot valid bits and probe control.
// Depends on rtl/lpht_pkg.sv.
// Undefined operations and zero keys skip the table; otherwise k slots are read,
// one per cycle, where k is 1 .. TABLE_SIZE (all slots for delete).
// One item in flight: the next is accepted the cycle after the result is loaded into
// the output register, which waits while it is full and m_ready is low. Reset clears
// the slot valid bits (all slots empty); the key memory itself is not cleared.
`default_nettype none

module linear_probe_hash_table (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire lpht_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output lpht_pkg::out_item_t       m_data
);

    // Key memory and slot valid bits
    logic [lpht_pkg::KEY_W-1:0]      mem [lpht_pkg::TABLE_SIZE];
    logic [lpht_pkg::TABLE_SIZE-1:0] valid_reg, valid_next;

    lpht_pkg::fsm_t                  state_reg, state_next;
    lpht_pkg::op_t                   op_reg, op_next;
    logic [lpht_pkg::KEY_W-1:0]      key_reg, key_next;

    // Probe issue side
    logic [lpht_pkg::IDX_W-1:0]      ptr_reg, ptr_next;
    logic [lpht_pkg::CNT_W-1:0]      cnt_reg, cnt_next;

    // Read data side (arrives the cycle after issue)
    logic [lpht_pkg::KEY_W-1:0]      rd_data_reg;
    logic                            rd_ent_vld_reg;
    logic [lpht_pkg::IDX_W-1:0]      rd_slot_reg;
    logic                            rd_live_reg, rd_live_next;
    logic                            rd_last_reg, rd_last_next;

    // Search/delete bookkeeping
    logic                            found_reg, found_next;
    logic [lpht_pkg::IDX_W-1:0]      first_reg, first_next;

    // Pending result and output register
    lpht_pkg::out_item_t             res_reg, res_next;
    logic                            m_valid_reg, m_valid_next;
    lpht_pkg::out_item_t             m_data_reg, m_data_next;

    // Datapath controls
    logic                            accept;
    logic                            early_done;
    logic                            issue;
    logic                            finish;
    logic                            wr_en;
    logic                            is_empty;
    logic                            is_match;
    logic                            out_free;

    assign s_ready = (state_reg == lpht_pkg::S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign is_empty = !rd_ent_vld_reg;
    assign is_match = rd_ent_vld_reg && (rd_data_reg == key_reg);
    assign issue    = (state_reg == lpht_pkg::S_SCAN)
                   && (cnt_reg < lpht_pkg::CNT_W'(lpht_pkg::TABLE_SIZE));

    // Undefined operation or zero key need no table access
    always_comb begin
        early_done = 1'b0;
        if (!(s_data.operation == lpht_pkg::OP_INSERT
              || s_data.operation == lpht_pkg::OP_SEARCH
              || s_data.operation == lpht_pkg::OP_DELETE)) begin
            early_done = 1'b1;
        end else if (s_data.key == '0) begin
            early_done = 1'b1;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpht_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = early_done ? lpht_pkg::S_RESP : lpht_pkg::S_SCAN;
                end
            end
            lpht_pkg::S_SCAN: begin
                if (finish) begin
                    state_next = lpht_pkg::S_RESP;
                end
            end
            lpht_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = lpht_pkg::S_IDLE;
                end
            end
            default: state_next = lpht_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        op_next      = op_reg;
        key_next     = key_reg;
        ptr_next     = ptr_reg;
        cnt_next     = cnt_reg;
        found_next   = found_reg;
        first_next   = first_reg;
        res_next     = res_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rd_live_next = 1'b0;
        rd_last_next = 1'b0;
        finish       = 1'b0;
        wr_en        = 1'b0;

        // Drop the output once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            lpht_pkg::S_IDLE: begin
                if (accept) begin
                    op_next    = s_data.operation;
                    key_next   = s_data.key;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    first_next = '0;
                    // Insert probes from the home slot, the others scan from slot 0
                    if (s_data.operation == lpht_pkg::OP_INSERT) begin
                        ptr_next = s_data.key[lpht_pkg::IDX_W-1:0];
                    end else begin
                        ptr_next = '0;
                    end
                    res_next.slot = '0;
                    if (!(s_data.operation == lpht_pkg::OP_INSERT
                          || s_data.operation == lpht_pkg::OP_SEARCH
                          || s_data.operation == lpht_pkg::OP_DELETE)) begin
                        res_next.status = lpht_pkg::ST_NOT_FOUND;
                    end else begin
                        res_next.status = lpht_pkg::ST_ZERO_KEY;
                    end
                end
            end
            lpht_pkg::S_SCAN: begin
                // Issue one slot read per cycle, wrapping at the table end
                if (issue) begin
                    rd_live_next = 1'b1;
                    rd_last_next = (cnt_reg == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SIZE - 1));
                    cnt_next     = cnt_reg + 1'b1;
                    if ({1'b0, ptr_reg} == lpht_pkg::CNT_W'(lpht_pkg::TABLE_SIZE - 1)) begin
                        ptr_next = '0;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                end
                // Check the slot whose data has returned
                if (rd_live_reg) begin
                    case (op_reg)
                        lpht_pkg::OP_INSERT: begin
                            if (is_empty) begin
                                wr_en                   = 1'b1;
                                valid_next[rd_slot_reg] = 1'b1;
                                finish                  = 1'b1;
                                res_next.status         = lpht_pkg::ST_DONE;
                                res_next.slot           = lpht_pkg::SLOT_W'(rd_slot_reg);
                            end else if (rd_last_reg) begin
                                finish          = 1'b1;
                                res_next.status = lpht_pkg::ST_FULL;
                                res_next.slot   = '0;
                            end
                        end
                        lpht_pkg::OP_SEARCH: begin
                            if (is_match) begin
                                finish          = 1'b1;
                                res_next.status = lpht_pkg::ST_DONE;
                                res_next.slot   = lpht_pkg::SLOT_W'(rd_slot_reg);
                            end else if (rd_last_reg) begin
                                finish          = 1'b1;
                                res_next.status = lpht_pkg::ST_NOT_FOUND;
                                res_next.slot   = '0;
                            end
                        end
                        default: begin
                            // Delete: empty every match, report the lowest
                            if (is_match) begin
                                valid_next[rd_slot_reg] = 1'b0;
                                if (!found_reg) begin
                                    found_next = 1'b1;
                                    first_next = rd_slot_reg;
                                end
                            end
                            if (rd_last_reg) begin
                                finish = 1'b1;
                                if (found_reg || is_match) begin
                                    res_next.status = lpht_pkg::ST_DONE;
                                    res_next.slot   = found_reg
                                        ? lpht_pkg::SLOT_W'(first_reg)
                                        : lpht_pkg::SLOT_W'(rd_slot_reg);
                                end else begin
                                    res_next.status = lpht_pkg::ST_NOT_FOUND;
                                    res_next.slot   = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            lpht_pkg::S_RESP: begin
                // Load the result once the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    // Key memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[rd_slot_reg] <= key_reg;
        end
        rd_data_reg <= mem[ptr_reg];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lpht_pkg::S_IDLE;
            valid_reg   <= '0;
            rd_live_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            rd_live_reg <= rd_live_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        ptr_reg        <= ptr_next;
        cnt_reg        <= cnt_next;
        found_reg      <= found_next;
        first_reg      <= first_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
        rd_last_reg    <= rd_last_next;
        rd_slot_reg    <= ptr_reg;
        rd_ent_vld_reg <= valid_reg[ptr_reg];
    end

endmodule : linear_probe_hash_table

`default_nettype wire

// ===== sim/linear_probe_hash_table_tb.sv =====
// Self-checking testbench for linear_probe_hash_table: directed and random
// insert/search/delete traffic with randomized idling on both channels.
// Depends on rtl/lpht_pkg.sv and rtl/linear_probe_hash_table.sv.
`default_nettype none

module linear_probe_hash_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Undefined operation code; the block must answer it with key-not-found
    localparam logic [1:0] OP_CODE_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    lpht_pkg::in_item_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    lpht_pkg::out_item_t m_data;

    // Stimulus and expectation stores
    lpht_pkg::in_item_t         pending_items [$];
    lpht_pkg::out_item_t        awaited_results [$];
    logic [lpht_pkg::KEY_W-1:0] live_keys [$];
    logic [lpht_pkg::KEY_W-1:0] slot_keys [lpht_pkg::TABLE_SIZE];

    int total_items  = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int idle_cycles  = 0;
    int send_wait    = 0;
    int send_calm    = 0;
    int recv_wait    = 0;
    int recv_calm    = 0;
    int hold_left    = 0;
    lpht_pkg::out_item_t want;

    linear_probe_hash_table uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Apply one operation to the shadow table and return its result
    function automatic lpht_pkg::out_item_t apply_to_table(input lpht_pkg::in_item_t item);
        lpht_pkg::out_item_t        res;
        logic [lpht_pkg::KEY_W-1:0] k;
        int                         pos;
        bit                         hit;
        res.status = lpht_pkg::ST_NOT_FOUND;
        res.slot   = '0;
        k   = item.key;
        hit = 1'b0;
        if (item.operation != lpht_pkg::OP_INSERT && item.operation != lpht_pkg::OP_SEARCH &&
            item.operation != lpht_pkg::OP_DELETE) begin
            res.status = lpht_pkg::ST_NOT_FOUND;
        end else if (k == '0) begin
            res.status = lpht_pkg::ST_ZERO_KEY;
        end else if (item.operation == lpht_pkg::OP_INSERT) begin
            // probe forward from the home slot, wrapping at the end
            pos = int'(k % lpht_pkg::TABLE_SIZE);
            for (int i = 0; i < lpht_pkg::TABLE_SIZE; i++) begin
                if (!hit && slot_keys[pos] == '0) begin
                    slot_keys[pos] = k;
                    res.status = lpht_pkg::ST_DONE;
                    res.slot   = lpht_pkg::SLOT_W'(pos);
                    hit = 1'b1;
                end
                pos = (pos == lpht_pkg::TABLE_SIZE - 1) ? 0 : pos + 1;
            end
            if (!hit) res.status = lpht_pkg::ST_FULL;
        end else begin
            // scan every slot; report the lowest match, clear all on delete
            for (int i = 0; i < lpht_pkg::TABLE_SIZE; i++) begin
                if (slot_keys[i] == k) begin
                    if (!hit) begin
                        res.status = lpht_pkg::ST_DONE;
                        res.slot   = lpht_pkg::SLOT_W'(i);
                        hit = 1'b1;
                    end
                    if (item.operation == lpht_pkg::OP_DELETE) slot_keys[i] = '0;
                end
            end
        end
        return res;
    endfunction

    function automatic int draw_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 50);
    endfunction

    // Random nonzero key; clustered keys crowd into a few home slots
    function automatic logic [lpht_pkg::KEY_W-1:0] fresh_key(input bit clustered);
        logic [lpht_pkg::KEY_W-1:0] k;
        k[31:0]                = $urandom;
        k[lpht_pkg::KEY_W-1:32] = 2'($urandom_range(0, 3));
        if (clustered) k[lpht_pkg::IDX_W-1:0] = lpht_pkg::IDX_W'($urandom_range(0, 3));
        if (k == '0) k = lpht_pkg::KEY_W'(1);
        return k;
    endfunction

    function automatic logic [lpht_pkg::KEY_W-1:0] pick_live();
        return live_keys[$urandom_range(0, live_keys.size() - 1)];
    endfunction

    // Queue one item and track which keys may still sit in the table
    task automatic push_item(input logic [1:0] code, input logic [lpht_pkg::KEY_W-1:0] k);
        lpht_pkg::in_item_t item;
        item.operation = lpht_pkg::op_t'(code);
        item.key       = k;
        pending_items.push_back(item);
        if (k != '0) begin
            if (code == lpht_pkg::OP_INSERT) begin
                live_keys.push_back(k);
            end else if (code == lpht_pkg::OP_DELETE) begin
                for (int i = live_keys.size() - 1; i >= 0; i--)
                    if (live_keys[i] == k) live_keys.delete(i);
            end
        end
    endtask

    // Driver: present queued items, predict each one on its transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_wait = 0;
            send_calm = 0;
            foreach (slot_keys[i]) slot_keys[i] = '0;
        end else begin
            if (s_valid && s_ready) awaited_results.push_back(apply_to_table(s_data));
            if (!s_valid || s_ready) begin
                if (send_wait != 0) begin
                    send_wait = send_wait - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                    if (send_calm != 0) begin
                        send_calm = send_calm - 1;
                    end else begin
                        send_wait = draw_idle();
                        if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(30, 80);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer and pace m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen = results_seen + 1;
                if (awaited_results.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result status %0d slot %0d",
                                 $time, m_data.status, m_data.slot);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.status !== want.status || m_data.slot !== want.slot) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"%0t: result %0d: expected status %0d slot %0d, ",
                                      "got status %0d slot %0d"},
                                     $time, results_seen, want.status, want.slot,
                                     m_data.status, m_data.slot);
                    end
                end
                if (recv_calm != 0) begin
                    recv_calm = recv_calm - 1;
                end else begin
                    recv_wait = draw_idle();
                    if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(30, 80);
                end
                // hold off once for a long stretch so the input side backs up
                if (results_seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (recv_wait != 0) begin
                recv_wait = recv_wait - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout after %0d cycles without a transfer", idle_cycles);
                $display("linear_probe_hash_table verification failed");
                $finish;
            end
        end
    end

    initial begin
        int                         phase_len;
        int                         bias;
        int                         roll;
        bit                         clustered;
        logic [1:0]                 code;
        logic [lpht_pkg::KEY_W-1:0] k;

        // Directed: zero key, unused code, wrap, duplicates, full table
        push_item(lpht_pkg::OP_SEARCH, 34'd1);
        push_item(lpht_pkg::OP_INSERT, '0);
        push_item(lpht_pkg::OP_SEARCH, '0);
        push_item(lpht_pkg::OP_DELETE, '0);
        push_item(OP_CODE_UNUSED, {lpht_pkg::KEY_W{1'b1}});
        push_item(OP_CODE_UNUSED, '0);
        push_item(lpht_pkg::OP_INSERT, {lpht_pkg::KEY_W{1'b1}});
        push_item(lpht_pkg::OP_INSERT, 34'h2_0000_000F);
        push_item(lpht_pkg::OP_INSERT, {lpht_pkg::KEY_W{1'b1}});
        push_item(lpht_pkg::OP_SEARCH, {lpht_pkg::KEY_W{1'b1}});
        push_item(lpht_pkg::OP_DELETE, {lpht_pkg::KEY_W{1'b1}});
        push_item(lpht_pkg::OP_SEARCH, {lpht_pkg::KEY_W{1'b1}});
        for (int i = 1; i < lpht_pkg::TABLE_SIZE; i++) begin
            k = fresh_key(1'b0);
            k[lpht_pkg::IDX_W-1:0] = lpht_pkg::IDX_W'(i);
            push_item(lpht_pkg::OP_INSERT, k);
        end
        push_item(lpht_pkg::OP_INSERT, fresh_key(1'b0));

        // Random phases that swing the table between full and empty
        while (pending_items.size() < RANDOM_ITEMS + 28) begin
            phase_len = $urandom_range(15, 60);
            bias      = $urandom_range(0, 2);
            clustered = $urandom_range(0, 1);
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    push_item(OP_CODE_UNUSED, fresh_key(1'b0));
                end else if (roll < 8) begin
                    code = 2'($urandom_range(0, 2));
                    push_item(code, '0);
                end else begin
                    roll = $urandom_range(0, 99);
                    case (bias)
                        0: code = (roll < 65) ? lpht_pkg::OP_INSERT :
                                  (roll < 85) ? lpht_pkg::OP_SEARCH : lpht_pkg::OP_DELETE;
                        1: code = (roll < 15) ? lpht_pkg::OP_INSERT :
                                  (roll < 40) ? lpht_pkg::OP_SEARCH : lpht_pkg::OP_DELETE;
                        default: code = (roll < 40) ? lpht_pkg::OP_INSERT :
                                        (roll < 70) ? lpht_pkg::OP_SEARCH : lpht_pkg::OP_DELETE;
                    endcase
                    if (code == lpht_pkg::OP_INSERT)
                        k = (live_keys.size() != 0 && $urandom_range(0, 3) == 0) ?
                            pick_live() : fresh_key(clustered);
                    else
                        k = (live_keys.size() != 0 && $urandom_range(0, 4) != 0) ?
                            pick_live() : fresh_key(1'b0);
                    push_item(code, k);
                end
            end
        end
        total_items = pending_items.size();

        // Hold reset, then release it on a clock edge
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every result, then watch for stragglers
        while (results_seen < total_items) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("linear_probe_hash_table verification clean");
        end else begin
            $display("linear_probe_hash_table verification failed");
        end
        $finish;
    end

endmodule : linear_probe_hash_table_tb

`default_nettype wire
